### design/tsb_pkg.sv
// Shared types and constants for the tick seconds counter and LED pattern blinker.
// Holds the transfer payload structs, register indexes and reset values.
// No dependencies.
package tsb_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned RATE_W     = 16;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned SECONDS_W  = 32;

    localparam logic [REG_IDX_W-1:0] REG_TICK_RATE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LED0_PATTERN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LED0_PERIOD  = 3'd2;

    localparam logic [RATE_W-1:0]   TICK_RATE_RESET = 16'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd1;

    localparam logic ACT_TICK     = 1'b0;
    localparam logic ACT_SET_TIME = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] time_value;
    } in_t;

    typedef struct packed {
        logic [31:0] seconds;
        logic        second_pulse;
        logic        led0_lit;
        logic        led1_lit;
    } out_t;

    typedef struct packed {
        logic wr_pattern;
        logic wr_period;
        logic tick;
    } led_ctl_t;

endpackage

### design/tsb_led.sv
// One LED channel: period counter, shifting pattern copy and drive register.
// Depends on tsb_pkg for the control struct and widths.
module tsb_led #(
    parameter int unsigned PATTERN_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tsb_pkg::led_ctl_t               ctl,
    input  logic [tsb_pkg::CFG_DATA_W-1:0]  data,
    output logic                            drive_next
);

    localparam int unsigned BL_W = $clog2(PATTERN_BITS + 1);

    logic [PATTERN_BITS-1:0]          pattern_reg, pattern_next;
    logic [tsb_pkg::PERIOD_W-1:0]     period_reg, period_next;
    logic [tsb_pkg::PERIOD_W-1:0]     count_reg, count_next;
    logic [PATTERN_BITS-1:0]          shift_reg, shift_next;
    logic [BL_W-1:0]                  bits_reg, bits_next;
    logic                             drive_reg;
    logic [PATTERN_BITS+tsb_pkg::CFG_DATA_W-1:0] data_wide;
    logic [tsb_pkg::PERIOD_W-1:0]     count_dec;
    logic [BL_W-1:0]                  bits_dec;

    assign data_wide = {{PATTERN_BITS{1'b0}}, data};
    assign count_dec = count_reg - 1'b1;
    assign bits_dec  = bits_reg - 1'b1;

    always_comb
    begin
        pattern_next = pattern_reg;
        period_next  = period_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        bits_next    = bits_reg;
        drive_next   = drive_reg;
        if (ctl.wr_pattern)
        begin
            pattern_next = data_wide[PATTERN_BITS-1:0];
        end
        if (ctl.wr_period)
        begin
            period_next = data[tsb_pkg::PERIOD_W-1:0];
        end
        if (ctl.wr_pattern || ctl.wr_period)
        begin
            count_next = tsb_pkg::PERIOD_W'(1);
            bits_next  = BL_W'(1);
            shift_next = pattern_next;
        end
        else if (ctl.tick)
        begin
            count_next = count_dec;
            if (count_dec == '0)
            begin
                count_next = period_reg;
                drive_next = shift_reg[0];
                if (bits_dec == '0)
                begin
                    bits_next  = BL_W'(PATTERN_BITS);
                    shift_next = pattern_reg;
                end
                else
                begin
                    bits_next  = bits_dec;
                    shift_next = shift_reg >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            period_reg  <= tsb_pkg::PERIOD_RESET;
            count_reg   <= tsb_pkg::PERIOD_W'(1);
            shift_reg   <= '0;
            bits_reg    <= BL_W'(1);
            drive_reg   <= 1'b0;
        end
        else
        begin
            pattern_reg <= pattern_next;
            period_reg  <= period_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            bits_reg    <= bits_next;
            drive_reg   <= drive_next;
        end
    end

endmodule

### design/tick_seconds_and_led_pattern_blinker.sv
// Each accepted item is either one system tick or a request to load the seconds counter, and
// every item yields exactly one result: the seconds count, a pulse when that tick completed a
// second, and the drive of each LED. An item is taken in every clock cycle while the output
// register is empty or being read; its result is registered in the single output register
// stage and appears in the next cycle. Writing a LED's pattern or period restarts that LED
// so the next tick shows bit 0; a period or tick rate of zero lasts 65536 ticks.
// Configuration is written through cfg_wen, cfg_index and cfg_data; a LED write acts at once,
// while a new tick rate is only used from the next reload of the rate counter.
module tick_seconds_and_led_pattern_blinker #(
    parameter int unsigned LED_COUNT    = 2,
    parameter int unsigned PATTERN_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [tsb_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [tsb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tsb_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tsb_pkg::out_t                   out_data
);

    localparam int unsigned NUM_LED = (LED_COUNT < 2) ? LED_COUNT : 2;

    logic [tsb_pkg::RATE_W-1:0]    tick_rate_reg, tick_rate_next;
    logic [tsb_pkg::RATE_W-1:0]    rate_reg, rate_next;
    logic [tsb_pkg::SECONDS_W-1:0] seconds_reg, seconds_next;
    logic                          out_valid_reg, out_valid_next;
    tsb_pkg::out_t                 out_data_reg, out_data_next;
    logic [tsb_pkg::RATE_W-1:0]    rate_dec;
    logic                          pulse;
    logic                          in_fire;
    logic                          tick;
    logic [1:0]                    drive_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign tick      = in_fire && (in_data.action == tsb_pkg::ACT_TICK);
    assign rate_dec  = rate_reg - 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    for (genvar g = 0; g < 2; g++)
    begin : g_led
        if (g < NUM_LED)
        begin : g_on
            tsb_pkg::led_ctl_t ctl;

            assign ctl.wr_pattern = cfg_wen && (cfg_index ==
                tsb_pkg::REG_IDX_W'(tsb_pkg::REG_LED0_PATTERN + 2 * g));
            assign ctl.wr_period  = cfg_wen && (cfg_index ==
                tsb_pkg::REG_IDX_W'(tsb_pkg::REG_LED0_PERIOD + 2 * g));
            assign ctl.tick       = tick;

            tsb_led #(
                .PATTERN_BITS(PATTERN_BITS)
            ) u_led (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .data      (cfg_data),
                .drive_next(drive_next[g])
            );
        end
        else
        begin : g_off
            assign drive_next[g] = 1'b0;
        end
    end

    always_comb
    begin
        tick_rate_next = tick_rate_reg;
        rate_next      = rate_reg;
        seconds_next   = seconds_reg;
        pulse          = 1'b0;
        if (cfg_wen && (cfg_index == tsb_pkg::REG_TICK_RATE))
        begin
            tick_rate_next = cfg_data[tsb_pkg::RATE_W-1:0];
        end
        if (in_fire)
        begin
            if (in_data.action == tsb_pkg::ACT_SET_TIME)
            begin
                seconds_next = in_data.time_value;
            end
            else if (rate_dec == '0)
            begin
                seconds_next = seconds_reg + 1'b1;
                rate_next    = tick_rate_reg;
                pulse        = 1'b1;
            end
            else
            begin
                rate_next = rate_dec;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_fire)
        begin
            out_valid_next             = 1'b1;
            out_data_next.seconds      = seconds_next;
            out_data_next.second_pulse = pulse;
            out_data_next.led0_lit     = drive_next[0];
            out_data_next.led1_lit     = drive_next[1];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= tsb_pkg::TICK_RATE_RESET;
            rate_reg      <= tsb_pkg::TICK_RATE_RESET;
            seconds_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tick_rate_reg <= tick_rate_next;
            rate_reg      <= rate_next;
            seconds_reg   <= seconds_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

### design/tsb_checker.sv
// Port-level checks for the tick seconds counter and LED pattern blinker.
// Depends on tsb_pkg; attached to the top level by the bind statement at the end.
module tsb_checker #(
    parameter int unsigned LED_COUNT = 2
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input tsb_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input tsb_pkg::out_t out_data
);

    // A result waiting to be taken must hold still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // With nothing held in the output register the block must take a transfer.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output register");

    // A set-time transfer loads the seconds count and never completes a second.
    a_set_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action == tsb_pkg::ACT_SET_TIME |=>
            out_valid && out_data.seconds == $past(in_data.time_value)
            && !out_data.second_pulse)
        else $error("set-time result wrong");

    // An absent second LED stays dark.
    a_led1_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (LED_COUNT > 1) || !out_data.led1_lit)
        else $error("absent LED lit");

endmodule

bind tick_seconds_and_led_pattern_blinker tsb_checker #(
    .LED_COUNT(LED_COUNT)
) u_tsb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);
